### hw/rtl/scs_pkg.sv
// ---------------------------------------------------------------------------
// scs_pkg
// shared types and fixed port widths of the sparse coordinate store
// ---------------------------------------------------------------------------
package scs_pkg;

  localparam int unsigned OpW    = 2;
  localparam int unsigned IndexW = 10;
  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 7;

  typedef enum logic [OpW-1:0] {
    OP_ASSIGN = 2'd0,
    OP_GET    = 2'd1,
    OP_ROW    = 2'd2,
    OP_MAX    = 2'd3
  } scs_op_e;

  typedef logic [IndexW-1:0] scs_index_t;

endpackage

### hw/rtl/scs_in_if.sv
// ---------------------------------------------------------------------------
// scs_in_if
// request channel: one operation word per handshake
// ---------------------------------------------------------------------------
interface scs_in_if;
  import scs_pkg::*;

  logic                     valid;
  logic                     ready;
  scs_op_e                  op;
  scs_index_t               row_index;
  scs_index_t               col_index;
  logic signed [WordW-1:0]  new_value;

  modport source (output valid, output op, output row_index, output col_index,
                  output new_value, input ready);
  modport sink   (input valid, input op, input row_index, input col_index,
                  input new_value, output ready);
endinterface

### hw/rtl/scs_out_if.sv
// ---------------------------------------------------------------------------
// scs_out_if
// result channel: one result word per handshake
// ---------------------------------------------------------------------------
interface scs_out_if;
  import scs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WordW-1:0]  read_value;
  logic                     has_value;
  logic                     last;
  logic                     table_full;
  logic [CountW-1:0]        entry_count;

  modport source (output valid, output read_value, output has_value, output last,
                  output table_full, output entry_count, input ready);
  modport sink   (input valid, input read_value, input has_value, input last,
                  input table_full, input entry_count, output ready);
endinterface

### hw/rtl/scs_entry_mem.sv
// ---------------------------------------------------------------------------
// scs_entry_mem
// entry table: one write port, one read port, registered read data
// ---------------------------------------------------------------------------
module scs_entry_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 52,
  parameter int unsigned AddrW = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/scs_ctrl.sv
// ---------------------------------------------------------------------------
// scs_ctrl
// operation sequencer: table scan, in-place update, append, removal shift,
// row streaming, maximum search and the result register
// ---------------------------------------------------------------------------
module scs_ctrl #(
  parameter int unsigned Capacity  = 64,
  parameter int unsigned DimBits   = 10,
  parameter int unsigned ValueBits = 32,
  parameter int unsigned CntW      = 7,
  parameter int unsigned IdxW      = 6,
  parameter int unsigned EntW      = 52
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  scs_in_if.sink          in_i,
  scs_out_if.source       out_o,
  output logic            mem_we_o,
  output logic [IdxW-1:0] mem_waddr_o,
  output logic [EntW-1:0] mem_wdata_o,
  output logic            mem_re_o,
  output logic [IdxW-1:0] mem_raddr_o,
  input  logic [EntW-1:0] mem_rdata_i
);
  import scs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_SHIFT = 3'b100
  } state_e;

  state_e                       state_q, state_d;
  scs_op_e                      op_q;
  logic [DimBits-1:0]           row_q, col_q;
  logic signed [ValueBits-1:0]  nv_q;
  logic [CntW-1:0]              count_q, count_d;
  logic [CntW-1:0]              rd_idx_q, rd_idx_d;
  logic                         dv_q, dv_d;
  logic [IdxW-1:0]              ex_idx_q, ex_idx_d;
  logic signed [ValueBits-1:0]  pend_q, pend_d;
  logic                         pend_v_q, pend_v_d;
  logic signed [ValueBits-1:0]  best_q, best_d;
  logic                         best_v_q, best_v_d;

  logic                         out_valid_q;
  logic signed [ValueBits-1:0]  out_val_q;
  logic                         out_has_q, out_last_q, out_full_q;
  logic [CntW-1:0]              out_cnt_q;

  logic [DimBits-1:0]           e_row, e_col;
  logic signed [ValueBits-1:0]  e_val;
  logic                         hit, row_hit, scan_end, can_load, accept;
  logic                         stall, leave;
  logic                         push, push_has, push_last, push_full;
  logic signed [ValueBits-1:0]  push_val;

  assign e_row = mem_rdata_i[EntW-1 -: DimBits];
  assign e_col = mem_rdata_i[ValueBits+DimBits-1 -: DimBits];
  assign e_val = mem_rdata_i[ValueBits-1:0];

  assign hit      = dv_q && (e_row == row_q) && (e_col == col_q);
  assign row_hit  = dv_q && (e_row == row_q);
  assign scan_end = !dv_q && (rd_idx_q >= count_q);
  assign can_load = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign accept   = in_i.valid && in_i.ready;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    dv_d        = dv_q;
    ex_idx_d    = ex_idx_q;
    pend_d      = pend_q;
    pend_v_d    = pend_v_q;
    best_d      = best_q;
    best_v_d    = best_v_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = rd_idx_q[IdxW-1:0];
    push        = 1'b0;
    push_val    = '0;
    push_has    = 1'b0;
    push_last   = 1'b0;
    push_full   = 1'b0;
    stall       = 1'b0;
    leave       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d  = S_SCAN;
          rd_idx_d = '0;
          dv_d     = 1'b0;
          pend_v_d = 1'b0;
          best_v_d = 1'b0;
        end
      end

      S_SCAN: begin
        if (scan_end) begin
          leave = 1'b1;
          if (can_load) begin
            state_d   = S_IDLE;
            push      = 1'b1;
            push_last = 1'b1;
            unique case (op_q)
              OP_ASSIGN: begin
                if (nv_q != '0) begin
                  if (count_q < CntW'(Capacity)) begin
                    mem_we_o    = 1'b1;
                    mem_waddr_o = count_q[IdxW-1:0];
                    mem_wdata_o = {row_q, col_q, nv_q};
                    count_d     = count_q + CntW'(1);
                  end else begin
                    push_full = 1'b1;
                  end
                end
              end
              OP_GET: begin
              end
              OP_ROW: begin
                push_val = pend_q;
                push_has = pend_v_q;
              end
              OP_MAX: begin
                push_val = best_q;
                push_has = best_v_q;
              end
              default: begin
              end
            endcase
            if (!push_has) begin
              push_val = '0;
            end
          end
        end else begin
          unique case (op_q)
            OP_ASSIGN: begin
              if (hit) begin
                leave = 1'b1;
                if (nv_q == '0) begin
                  state_d  = S_SHIFT;
                  rd_idx_d = CntW'(ex_idx_q) + CntW'(1);
                  dv_d     = 1'b0;
                end else if (can_load) begin
                  mem_we_o    = 1'b1;
                  mem_waddr_o = ex_idx_q;
                  mem_wdata_o = {row_q, col_q, nv_q};
                  push        = 1'b1;
                  push_last   = 1'b1;
                  state_d     = S_IDLE;
                end else begin
                  stall = 1'b1;
                end
              end
            end
            OP_GET: begin
              if (hit) begin
                leave = 1'b1;
                if (can_load) begin
                  push      = 1'b1;
                  push_val  = e_val;
                  push_has  = 1'b1;
                  push_last = 1'b1;
                  state_d   = S_IDLE;
                end else begin
                  stall = 1'b1;
                end
              end
            end
            OP_ROW: begin
              if (row_hit) begin
                if (pend_v_q) begin
                  if (can_load) begin
                    push     = 1'b1;
                    push_val = pend_q;
                    push_has = 1'b1;
                  end else begin
                    stall = 1'b1;
                  end
                end
                if (!stall) begin
                  pend_d   = e_val;
                  pend_v_d = 1'b1;
                end
              end
            end
            OP_MAX: begin
              if (dv_q && (!best_v_q || (e_val > best_q))) begin
                best_d   = e_val;
                best_v_d = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end

        if (!leave && !stall) begin
          if (rd_idx_q < count_q) begin
            mem_re_o = 1'b1;
            rd_idx_d = rd_idx_q + CntW'(1);
            dv_d     = 1'b1;
            ex_idx_d = rd_idx_q[IdxW-1:0];
          end else begin
            dv_d = 1'b0;
          end
        end
      end

      S_SHIFT: begin
        if (dv_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = ex_idx_q - IdxW'(1);
          mem_wdata_o = mem_rdata_i;
        end
        if (scan_end) begin
          if (can_load) begin
            count_d   = count_q - CntW'(1);
            push      = 1'b1;
            push_last = 1'b1;
            state_d   = S_IDLE;
          end
        end else if (rd_idx_q < count_q) begin
          mem_re_o = 1'b1;
          rd_idx_d = rd_idx_q + CntW'(1);
          dv_d     = 1'b1;
          ex_idx_d = rd_idx_q[IdxW-1:0];
        end else begin
          dv_d = 1'b0;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_idx_q    <= '0;
      dv_q        <= 1'b0;
      pend_v_q    <= 1'b0;
      best_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_idx_q <= rd_idx_d;
      dv_q     <= dv_d;
      pend_v_q <= pend_v_d;
      best_v_q <= best_v_d;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ex_idx_q <= ex_idx_d;
    pend_q   <= pend_d;
    best_q   <= best_d;
    if (accept) begin
      op_q  <= in_i.op;
      row_q <= DimBits'(in_i.row_index);
      col_q <= DimBits'(in_i.col_index);
      nv_q  <= ValueBits'(in_i.new_value);
    end
    if (push) begin
      out_val_q  <= push_val;
      out_has_q  <= push_has;
      out_last_q <= push_last;
      out_full_q <= push_full;
      out_cnt_q  <= count_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.read_value  = WordW'(out_val_q);
  assign out_o.has_value   = out_has_q;
  assign out_o.last        = out_last_q;
  assign out_o.table_full  = out_full_q;
  assign out_o.entry_count = CountW'(out_cnt_q);

endmodule

### hw/rtl/sparse_coordinate_store.sv
// ---------------------------------------------------------------------------
// sparse_coordinate_store
// coordinate-list sparse matrix store with assign, get, get_row and get_max
//
// in_i carries one operation word (op, row_index, col_index, new_value),
// out_o returns result words; every operation ends with a word marked last.
// assign gives one word (table_full set when an append finds no room), get
// gives one word, get_row one word per stored element of the row in storage
// order (one empty word for an empty row), get_max one word.
// entries live in a single-port-read, single-port-write table read one entry
// per cycle unless the scan waits on the output register; get and update stop
// at the first hit, and a removal then shifts later entries down by one place.
// in_i is ready again from the edge that loads the final word, so the next
// word is accepted while that result still sits in the output register.
// when out_o stalls, every operation holds at its next word until the output
// register is free.
// reset empties the table at once: the entry count goes to zero and no
// clearing pass is needed.
// ---------------------------------------------------------------------------
module sparse_coordinate_store #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned DIM_BITS   = 10,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  scs_in_if.sink     in_i,
  scs_out_if.source  out_o
);
  import scs_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned EntW = 2 * DIM_BITS + VALUE_BITS;

  logic            mem_we, mem_re;
  logic [IdxW-1:0] mem_waddr, mem_raddr;
  logic [EntW-1:0] mem_wdata, mem_rdata;

  scs_ctrl #(
    .Capacity  (CAPACITY),
    .DimBits   (DIM_BITS),
    .ValueBits (VALUE_BITS),
    .CntW      (CntW),
    .IdxW      (IdxW),
    .EntW      (EntW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  scs_entry_mem #(
    .Depth (CAPACITY),
    .Width (EntW),
    .AddrW (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
